>>> rtl/apgs_pkg.sv
package apgs_pkg;

  localparam int ALPHABET_SIZE = 32;
  localparam int TABLE_DIM     = 32;
  localparam int IDX_W         = 5;
  localparam int CHAR_W        = 8;
  localparam int ENTRY_W       = 8;
  localparam int SCORE_W       = 16;
  localparam int PEN_W         = 8;
  localparam int MAP_DEPTH     = 256;
  localparam int TABLE_DEPTH   = TABLE_DIM * TABLE_DIM;
  localparam int TABLE_AW      = 2 * IDX_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic [CHAR_W-1:0] GAP_DASH       = 8'h2D;
  localparam logic [CHAR_W-1:0] GAP_UNDERSCORE = 8'h5F;

  localparam logic [IDX_W:0] ALPHA_LIMIT = (IDX_W + 1)'(ALPHABET_SIZE);

  typedef enum logic [1:0] {
    CMD_SCORE      = 2'd0,
    CMD_LOAD_ENTRY = 2'd1,
    CMD_LOAD_MAP   = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_GAP_OPEN   = 1'b0,
    CFG_GAP_EXTEND = 1'b1
  } cfg_idx_t;

  function automatic logic is_gap_char(input logic [CHAR_W-1:0] c);
    return (c == GAP_DASH) || (c == GAP_UNDERSCORE);
  endfunction

endpackage

>>> rtl/apgs_ram.sv
module apgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/aligned_pair_affine_gap_score.sv
// Affine-gap score of an aligned sequence pair, one column per input transfer.
// One item is accepted every cycle while the result side takes results. A
// score column passes in order through the registered symbol-map read, the
// registered substitution-table read, and the output register that holds
// the accumulated sum and drives out_tvalid. A stall on the result side
// holds the whole pipeline.
// Load and clear items give no result and restart the sum. The symbol map
// and substitution table are memories with no reset: score only columns
// whose symbols and table entries have been loaded.
module aligned_pair_affine_gap_score (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // char_a[7:0], char_b[15:8], row_index[20:16], col_index[25:21],
  // entry_value[33:26], zero[39:34]
  input  logic [apgs_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // running_score[15:0], in_gap[16], zero[23:17]
  output logic [apgs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [apgs_pkg::PEN_W-1:0]       cfg_wdata
);

  logic                              adv;
  apgs_pkg::cmd_t                    in_cmd;
  logic [apgs_pkg::CHAR_W-1:0]       in_char_a;
  logic [apgs_pkg::CHAR_W-1:0]       in_char_b;
  logic [apgs_pkg::IDX_W-1:0]        in_row;
  logic [apgs_pkg::IDX_W-1:0]        in_col;
  logic [apgs_pkg::ENTRY_W-1:0]      in_entry;
  logic                              in_xfer;

  logic [apgs_pkg::PEN_W-1:0]        gap_open_r;
  logic [apgs_pkg::PEN_W-1:0]        gap_extend_r;

  logic                              s1_valid_r;
  apgs_pkg::cmd_t                    s1_cmd_r;
  logic                              s1_gap_r;
  logic [apgs_pkg::IDX_W-1:0]        s1_row_r;
  logic [apgs_pkg::IDX_W-1:0]        s1_col_r;
  logic [apgs_pkg::ENTRY_W-1:0]      s1_entry_r;

  logic                              s2_valid_r;
  apgs_pkg::cmd_t                    s2_cmd_r;
  logic                              s2_gap_r;

  logic [apgs_pkg::IDX_W-1:0]        map_a;
  logic [apgs_pkg::IDX_W-1:0]        map_b;
  logic                              map_we;
  logic                              tab_we;
  logic [apgs_pkg::ENTRY_W-1:0]      tab_rdata;

  logic [apgs_pkg::SCORE_W-1:0]      sum_r;
  logic [apgs_pkg::SCORE_W-1:0]      sum_nxt;
  logic                              gap_r;
  logic                              gap_nxt;
  logic [apgs_pkg::SCORE_W-1:0]      addend;

  logic                              out_valid_r;
  logic [apgs_pkg::SCORE_W-1:0]      out_score_r;
  logic                              out_gap_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_xfer   = in_tvalid && adv;

  assign in_cmd    = apgs_pkg::cmd_t'(in_tuser);
  assign in_char_a = in_tdata[7:0];
  assign in_char_b = in_tdata[15:8];
  assign in_row    = in_tdata[20:16];
  assign in_col    = in_tdata[25:21];
  assign in_entry  = in_tdata[33:26];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_open_r   <= 8'hF6;
      gap_extend_r <= 8'hFF;
    end else if (cfg_we) begin
      unique case (apgs_pkg::cfg_idx_t'(cfg_index))
        apgs_pkg::CFG_GAP_OPEN:   gap_open_r   <= cfg_wdata;
        apgs_pkg::CFG_GAP_EXTEND: gap_extend_r <= cfg_wdata;
      endcase
    end
  end

  assign map_we = in_xfer && (in_cmd == apgs_pkg::CMD_LOAD_MAP)
                  && ({1'b0, in_row} < apgs_pkg::ALPHA_LIMIT);

  apgs_ram #(
    .WIDTH (apgs_pkg::IDX_W),
    .DEPTH (apgs_pkg::MAP_DEPTH)
  ) u_map_a (
    .clk   (clk),
    .we    (map_we),
    .waddr (in_char_a),
    .wdata (in_row),
    .re    (adv),
    .raddr (in_char_a),
    .rdata (map_a)
  );

  apgs_ram #(
    .WIDTH (apgs_pkg::IDX_W),
    .DEPTH (apgs_pkg::MAP_DEPTH)
  ) u_map_b (
    .clk   (clk),
    .we    (map_we),
    .waddr (in_char_a),
    .wdata (in_row),
    .re    (adv),
    .raddr (in_char_b),
    .rdata (map_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r   <= in_cmd;
      s1_gap_r   <= apgs_pkg::is_gap_char(in_char_a) || apgs_pkg::is_gap_char(in_char_b);
      s1_row_r   <= in_row;
      s1_col_r   <= in_col;
      s1_entry_r <= in_entry;
      s2_cmd_r   <= s1_cmd_r;
      s2_gap_r   <= s1_gap_r;
    end
  end

  assign tab_we = adv && s1_valid_r && (s1_cmd_r == apgs_pkg::CMD_LOAD_ENTRY)
                  && ({1'b0, s1_row_r} < apgs_pkg::ALPHA_LIMIT)
                  && ({1'b0, s1_col_r} < apgs_pkg::ALPHA_LIMIT);

  apgs_ram #(
    .WIDTH (apgs_pkg::ENTRY_W),
    .DEPTH (apgs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr ({s1_row_r, s1_col_r}),
    .wdata (s1_entry_r),
    .re    (adv),
    .raddr ({map_a, map_b}),
    .rdata (tab_rdata)
  );

  always_comb begin
    sum_nxt = sum_r;
    gap_nxt = gap_r;
    addend  = '0;
    if (s2_gap_r) begin
      if (gap_r) begin
        addend = {{(apgs_pkg::SCORE_W - apgs_pkg::PEN_W){gap_extend_r[apgs_pkg::PEN_W-1]}},
                  gap_extend_r};
      end else begin
        addend = {{(apgs_pkg::SCORE_W - apgs_pkg::PEN_W){gap_open_r[apgs_pkg::PEN_W-1]}},
                  gap_open_r};
      end
    end else begin
      addend = {{(apgs_pkg::SCORE_W - apgs_pkg::ENTRY_W){tab_rdata[apgs_pkg::ENTRY_W-1]}},
                tab_rdata};
    end
    if (adv && s2_valid_r) begin
      if (s2_cmd_r == apgs_pkg::CMD_SCORE) begin
        sum_nxt = sum_r + addend;
        gap_nxt = s2_gap_r;
      end else begin
        sum_nxt = '0;
        gap_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      gap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      gap_r <= gap_nxt;
      if (adv) begin
        out_valid_r <= s2_valid_r && (s2_cmd_r == apgs_pkg::CMD_SCORE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_score_r <= sum_nxt;
      out_gap_r   <= gap_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(apgs_pkg::OUT_DATA_W - apgs_pkg::SCORE_W - 1){1'b0}},
                       out_gap_r, out_score_r};

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import apgs_pkg::*;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] ca;
    logic [7:0] cb;
    logic [4:0] row;
    logic [4:0] col;
    logic [7:0] val;
  } column_t;

  typedef struct {
    logic [15:0] score;
    logic        in_gap;
  } score_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [PEN_W-1:0]      cfg_wdata = '0;

  aligned_pair_affine_gap_score dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  column_t pending_items[$];
  score_t  expected_scores[$];

  // scoring state as the block should hold it
  logic [7:0]  open_pen   = 8'hF6;
  logic [7:0]  extend_pen = 8'hFF;
  logic [15:0] score_acc  = '0;
  logic        run_open   = 1'b0;
  logic [7:0]  sub_tab [TABLE_DEPTH];
  logic [4:0]  sym_map [MAP_DEPTH];

  // what the stimulus has loaded so far, in issue order
  logic [4:0]  gen_sym     [MAP_DEPTH];
  bit          gen_sym_set [MAP_DEPTH];
  bit          gen_ent_set [TABLE_DEPTH];
  int          items_made = 0;

  int          cyc = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mismatches = 0;
  score_t      want;
  wire         quiet = (cyc >= 400) && (cyc < 900);

  function automatic logic indel(input logic [7:0] c);
    return (c == GAP_DASH) || (c == GAP_UNDERSCORE);
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

  task automatic advance_score(input column_t c);
    logic [15:0] add;
    if (c.cmd == CMD_SCORE) begin
      if (indel(c.ca) || indel(c.cb)) begin
        add = run_open ? sext8(extend_pen) : sext8(open_pen);
        run_open = 1'b1;
      end else begin
        add = sext8(sub_tab[{sym_map[c.ca], sym_map[c.cb]}]);
        run_open = 1'b0;
      end
      score_acc = score_acc + add;
      expected_scores.push_back('{score_acc, run_open});
    end else begin
      if (c.cmd == CMD_LOAD_ENTRY && c.row < ALPHABET_SIZE && c.col < ALPHABET_SIZE)
        sub_tab[{c.row, c.col}] = c.val;
      if (c.cmd == CMD_LOAD_MAP && c.row < ALPHABET_SIZE)
        sym_map[c.ca] = c.row;
      score_acc = '0;
      run_open  = 1'b0;
    end
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [4:0] rnd5();
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = rnd8(); while (indel(c));
    return c;
  endfunction

  function automatic logic [7:0] gap_sym();
    return $urandom_range(0, 1) ? GAP_DASH : GAP_UNDERSCORE;
  endfunction

  function automatic logic [7:0] skewed_entry();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h7F;
    if (r == 1) return 8'h80;
    return rnd8();
  endfunction

  task automatic push_item(input cmd_t cmd, input logic [7:0] a, input logic [7:0] b,
                           input logic [4:0] r, input logic [4:0] cl, input logic [7:0] v);
    if (cmd == CMD_LOAD_ENTRY)
      gen_ent_set[{r, cl}] = 1'b1;
    if (cmd == CMD_LOAD_MAP) begin
      gen_sym[a]     = r;
      gen_sym_set[a] = 1'b1;
    end
    pending_items.push_back('{cmd, a, b, r, cl, v});
    items_made++;
  endtask

  // fall back to a gap column when the pair would read an unloaded entry
  task automatic push_column(input logic [7:0] a, input logic [7:0] b);
    if (!indel(a) && !indel(b) &&
        !(gen_sym_set[a] && gen_sym_set[b] && gen_ent_set[{gen_sym[a], gen_sym[b]}]))
      a = GAP_DASH;
    push_item(CMD_SCORE, a, b, rnd5(), rnd5(), rnd8());
  endtask

  task automatic push_gap_column();
    case ($urandom_range(0, 2))
      0: push_item(CMD_SCORE, gap_sym(), rnd8(), rnd5(), rnd5(), rnd8());
      1: push_item(CMD_SCORE, rnd8(), gap_sym(), rnd5(), rnd5(), rnd8());
      default: push_item(CMD_SCORE, gap_sym(), gap_sym(), rnd5(), rnd5(), rnd8());
    endcase
  endtask

  task automatic run_burst(input int cols);
    logic [7:0] syms [4];
    int k;
    int r;
    k = $urandom_range(2, 4);
    for (int i = 0; i < k; i++) begin
      syms[i] = plain_char();
      push_item(CMD_LOAD_MAP, syms[i], rnd8(), rnd5(), rnd5(), rnd8());
    end
    for (int i = 0; i < k; i++)
      for (int j = 0; j < k; j++)
        if (!gen_ent_set[{gen_sym[syms[i]], gen_sym[syms[j]]}] || $urandom_range(0, 3) == 0)
          push_item(CMD_LOAD_ENTRY, rnd8(), rnd8(), gen_sym[syms[i]], gen_sym[syms[j]],
                    skewed_entry());
    for (int n = 0; n < cols; n++) begin
      r = $urandom_range(0, 99);
      if (r < 58)
        push_column(syms[$urandom_range(0, k-1)], syms[$urandom_range(0, k-1)]);
      else if (r < 88)
        repeat ($urandom_range(1, 4)) push_gap_column();
      else if (r < 93)
        push_item(CMD_CLEAR, rnd8(), rnd8(), rnd5(), rnd5(), rnd8());
      else if (r < 97)
        push_item(CMD_LOAD_MAP, rnd8(), rnd8(), rnd5(), rnd5(), rnd8());
      else
        push_item(CMD_LOAD_ENTRY, rnd8(), rnd8(), rnd5(), rnd5(), skewed_entry());
    end
  endtask

  task automatic fill_phase(input int budget);
    int start;
    start = items_made;
    while (items_made - start < budget)
      run_burst($urandom_range(5, 40));
  endtask

  // clear, then one long gap run so the sum wraps
  task automatic push_gap_run(input int len);
    push_item(CMD_CLEAR, rnd8(), rnd8(), rnd5(), rnd5(), rnd8());
    repeat (len) push_gap_column();
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_scores.size() != 0 || in_tvalid)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GAP_OPEN)
      open_pen = v;
    else
      extend_pen = v;
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %h got %h", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk)
    cyc <= cyc + 1;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        advance_score(pending_items.pop_front());
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 38)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, pending_items[0].val, pending_items[0].col,
                        pending_items[0].row, pending_items[0].cb, pending_items[0].ca};
          in_tuser  <= pending_items[0].cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 50) begin
      hold_left <= 80;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_scores.size() == 0) begin
          report_mismatch("unexpected transfer", 'x, out_tdata[15:0]);
        end else begin
          want = expected_scores.pop_front();
          if (out_tdata[15:0] !== want.score)
            report_mismatch("running_score", want.score, out_tdata[15:0]);
          if (out_tdata[16] !== want.in_gap)
            report_mismatch("in_gap", 16'(want.in_gap), 16'(out_tdata[16]));
        end
      end
      out_tready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 38);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_item(CMD_LOAD_MAP, 8'h41, rnd8(), 5'd0, rnd5(), rnd8());
    push_item(CMD_LOAD_MAP, 8'hFF, rnd8(), 5'd31, rnd5(), rnd8());
    push_item(CMD_LOAD_MAP, 8'h00, rnd8(), 5'd15, rnd5(), rnd8());
    push_item(CMD_LOAD_ENTRY, rnd8(), rnd8(), 5'd0, 5'd0, 8'h7F);
    push_item(CMD_LOAD_ENTRY, rnd8(), rnd8(), 5'd0, 5'd31, 8'h80);
    push_item(CMD_LOAD_ENTRY, rnd8(), rnd8(), 5'd31, 5'd0, 8'h00);
    push_item(CMD_LOAD_ENTRY, rnd8(), rnd8(), 5'd31, 5'd31, 8'hFF);
    push_item(CMD_LOAD_ENTRY, rnd8(), rnd8(), 5'd15, 5'd15, 8'h01);
    push_column(8'h41, 8'h41);
    push_column(8'h41, 8'hFF);
    push_column(GAP_DASH, 8'h41);
    push_column(GAP_UNDERSCORE, GAP_UNDERSCORE);
    push_column(8'hFF, GAP_DASH);
    push_column(8'hFF, 8'h41);
    push_column(8'hFF, 8'hFF);
    push_item(CMD_CLEAR, 8'hFF, 8'hFF, 5'd31, 5'd31, 8'hFF);
    push_column(GAP_DASH, 8'h00);
    push_column(8'h00, 8'h00);
    push_item(CMD_LOAD_MAP, 8'h41, rnd8(), 5'd31, rnd5(), rnd8());
    push_column(8'h41, 8'h41);
    push_column(GAP_UNDERSCORE, 8'h00);
    push_item(CMD_LOAD_ENTRY, rnd8(), rnd8(), 5'd31, 5'd31, 8'h7F);
    push_column(GAP_DASH, GAP_DASH);
    fill_phase(60);
    drain();

    write_reg(CFG_GAP_OPEN, 8'h7F);
    write_reg(CFG_GAP_EXTEND, 8'h7F);
    @(negedge clk);
    fill_phase(25);
    push_gap_run(265);
    drain();

    write_reg(CFG_GAP_OPEN, 8'h80);
    write_reg(CFG_GAP_EXTEND, 8'h80);
    @(negedge clk);
    fill_phase(25);
    push_gap_run(265);
    drain();

    write_reg(CFG_GAP_OPEN, rnd8());
    write_reg(CFG_GAP_EXTEND, rnd8());
    @(negedge clk);
    fill_phase(40);
    drain();

    repeat (10) @(negedge clk);
    if (expected_scores.size() != 0)
      mismatches++;
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
